// ----- sv/fspa_pkg.sv -----
// ----------------------------------------------------------------------------
// fspa_pkg: shared types and constants of the fixed-slot pool allocator
// Widths, opcode and status codes, and the command/status bundles that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package fspa_pkg;

	// built capacity of the link memory
	localparam int CAPACITY = 1024;

	// field widths
	localparam int ADDR_W  = 48;
	localparam int SIZE_W  = 16;
	localparam int COUNT_W = 11;
	localparam int OP_W    = 2;
	localparam int STAT_W  = 2;
	localparam int IDX_W   = 2;

	// derived widths
	localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int LINK_W = $clog2(CAPACITY + 1);
	localparam int LIM_W  = COUNT_W + SIZE_W;
	localparam int REM_W  = SIZE_W + SLOT_W;
	localparam int PROD_W = SLOT_W + SIZE_W;
	localparam int K_W    = $clog2(SLOT_W + 1);

	// null link marks the end of the free chain
	localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(CAPACITY);

	// register reset values
	localparam logic [ADDR_W-1:0]  BASE_RST  = '0;
	localparam logic [SIZE_W-1:0]  SIZE_RST  = SIZE_W'(64);
	localparam logic [COUNT_W-1:0] COUNT_RST = COUNT_W'(1024);
	localparam logic [COUNT_W-1:0] N_RST     =
		(32'(COUNT_RST) < 32'(CAPACITY)) ? COUNT_RST : COUNT_W'(CAPACITY);

	// register indexes
	localparam logic [IDX_W-1:0] REG_POOL_BASE  = 2'd0;
	localparam logic [IDX_W-1:0] REG_SLOT_SIZE  = 2'd1;
	localparam logic [IDX_W-1:0] REG_SLOT_COUNT = 2'd2;

	// opcodes
	localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
	localparam logic [OP_W-1:0] OP_REBUILD = 2'd2;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_BAD   = 2'd2;

	// controller -> datapath commands
	typedef struct packed {
		logic              capture;
		logic              sweep_start;
		logic              sweep_step;
		logic              alloc_rd;
		logic              alloc_wb;
		logic              free_prep;
		logic              free_init;
		logic              div_step;
		logic              link_null;
		logic              free_rd;
		logic              free_w1;
		logic              free_w2;
		logic              res_set;
		logic [STAT_W-1:0] res_status;
		logic              out_load;
	} cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic head_null;
		logic sweep_last;
		logic free_bad;
		logic div_last;
		logic rem_nz;
		logic out_busy;
	} sts_t;

endpackage

// ----- sv/fspa_ctrl.sv -----
// ----------------------------------------------------------------------------
// fspa_ctrl: sequencing of the pool allocator
// Walks each operation through its datapath steps, runs the chain sweep
// after reset and on rebuild, and hands the result to the output register.
// ----------------------------------------------------------------------------
module fspa_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [fspa_pkg::OP_W-1:0]  opcode,
	input  fspa_pkg::sts_t             sts,
	output fspa_pkg::cmd_t             cmd
);

	localparam logic [3:0] S_INIT    = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_REBUILD = 4'd2;
	localparam logic [3:0] S_A_RD    = 4'd3;
	localparam logic [3:0] S_A_WB    = 4'd4;
	localparam logic [3:0] S_F_SUB   = 4'd5;
	localparam logic [3:0] S_F_INIT  = 4'd6;
	localparam logic [3:0] S_F_DIV   = 4'd7;
	localparam logic [3:0] S_F_CHK   = 4'd8;
	localparam logic [3:0] S_F_W1    = 4'd9;
	localparam logic [3:0] S_F_W2    = 4'd10;
	localparam logic [3:0] S_DONE    = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_INIT: begin
				cmd.sweep_step = 1'b1;
				if (sts.sweep_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					case (opcode)
						fspa_pkg::OP_ALLOC: state_d = S_A_RD;
						fspa_pkg::OP_FREE:  state_d = S_F_SUB;
						fspa_pkg::OP_REBUILD: begin
							cmd.sweep_start = 1'b1;
							cmd.res_set     = 1'b1;
							cmd.res_status  = fspa_pkg::ST_OK;
							state_d         = S_REBUILD;
						end
						default: begin
							cmd.res_set    = 1'b1;
							cmd.res_status = fspa_pkg::ST_OK;
							state_d        = S_DONE;
						end
					endcase
				end
			end
			S_REBUILD: begin
				cmd.sweep_step = 1'b1;
				if (sts.sweep_last) state_d = S_DONE;
			end
			S_A_RD: begin
				if (sts.head_null) begin
					cmd.res_set    = 1'b1;
					cmd.res_status = fspa_pkg::ST_EMPTY;
					state_d        = S_DONE;
				end else begin
					cmd.alloc_rd = 1'b1;
					state_d      = S_A_WB;
				end
			end
			S_A_WB: begin
				cmd.alloc_wb = 1'b1;
				state_d      = S_DONE;
			end
			S_F_SUB: begin
				cmd.free_prep = 1'b1;
				state_d       = S_F_INIT;
			end
			S_F_INIT: begin
				cmd.free_init = 1'b1;
				state_d       = S_F_DIV;
			end
			S_F_DIV: begin
				if (sts.free_bad) begin
					cmd.res_set    = 1'b1;
					cmd.res_status = fspa_pkg::ST_BAD;
					state_d        = S_DONE;
				end else begin
					cmd.div_step = 1'b1;
					if (sts.div_last) state_d = S_F_CHK;
				end
			end
			S_F_CHK: begin
				cmd.res_set = 1'b1;
				if (sts.rem_nz) begin
					cmd.res_status = fspa_pkg::ST_BAD;
					state_d        = S_DONE;
				end else if (sts.head_null) begin
					cmd.res_status = fspa_pkg::ST_OK;
					cmd.link_null  = 1'b1;
					state_d        = S_DONE;
				end else begin
					cmd.res_status = fspa_pkg::ST_OK;
					cmd.free_rd    = 1'b1;
					state_d        = S_F_W1;
				end
			end
			S_F_W1: begin
				cmd.free_w1 = 1'b1;
				state_d     = S_F_W2;
			end
			S_F_W2: begin
				cmd.free_w2 = 1'b1;
				state_d     = S_DONE;
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- sv/fspa_dp.sv -----
// ----------------------------------------------------------------------------
// fspa_dp: datapath of the pool allocator
// Configuration registers, free-list head, link memory, slot address
// multiplier, restoring divider for free, result and output registers.
// ----------------------------------------------------------------------------
module fspa_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  fspa_pkg::cmd_t                 cmd,
	output fspa_pkg::sts_t                 sts,
	// configuration writes
	input  logic                           cfg_we,
	input  logic [fspa_pkg::IDX_W-1:0]     cfg_index,
	input  logic [fspa_pkg::ADDR_W-1:0]    cfg_data,
	// input payload
	input  logic [fspa_pkg::ADDR_W-1:0]    object_address,
	// output register
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [fspa_pkg::ADDR_W-1:0]    alloc_address,
	output logic [fspa_pkg::STAT_W-1:0]    status,
	output logic                           last_taken
);

	localparam int ADDR_W  = fspa_pkg::ADDR_W;
	localparam int SIZE_W  = fspa_pkg::SIZE_W;
	localparam int COUNT_W = fspa_pkg::COUNT_W;
	localparam int SLOT_W  = fspa_pkg::SLOT_W;
	localparam int LINK_W  = fspa_pkg::LINK_W;
	localparam int LIM_W   = fspa_pkg::LIM_W;
	localparam int REM_W   = fspa_pkg::REM_W;
	localparam int PROD_W  = fspa_pkg::PROD_W;
	localparam int K_W     = fspa_pkg::K_W;

	// config registers
	logic [ADDR_W-1:0]  pool_base_q;
	logic [SIZE_W-1:0]  slot_size_q;
	logic [COUNT_W-1:0] slot_count_q;
	logic [COUNT_W-1:0] active_n;

	// free-list state
	logic [LINK_W-1:0]  head_q;
	logic [LINK_W-1:0]  mem [fspa_pkg::CAPACITY];
	logic [LINK_W-1:0]  rd_q;
	logic               mem_we;
	logic [SLOT_W-1:0]  mem_wa;
	logic [LINK_W-1:0]  mem_wd;
	logic               mem_re;

	// chain sweep
	logic [SLOT_W-1:0]  sweep_i_q;
	logic [COUNT_W-1:0] sweep_n_q;
	logic [LINK_W-1:0]  sweep_link;

	// work registers
	logic [ADDR_W-1:0]  addr_q;
	logic [PROD_W-1:0]  prod_q;
	logic [ADDR_W-1:0]  off_q;
	logic               under_q;
	logic [LIM_W-1:0]   lim_q;
	logic               bad_q;
	logic [REM_W-1:0]   rem_q;
	logic [REM_W-1:0]   div_sub;
	logic [SLOT_W-1:0]  quo_q;
	logic [K_W-1:0]     k_q;
	logic [ADDR_W:0]    diff;

	// result and output
	logic [ADDR_W-1:0]  res_addr_q;
	logic [fspa_pkg::STAT_W-1:0] res_status_q;
	logic               res_last_q;
	logic               out_valid_q;
	logic [ADDR_W-1:0]  out_addr_q;
	logic [fspa_pkg::STAT_W-1:0] out_status_q;
	logic               out_last_q;

	// slots in use, clipped to the built capacity
	assign active_n = (32'(slot_count_q) < 32'(fspa_pkg::CAPACITY)) ?
		slot_count_q : COUNT_W'(fspa_pkg::CAPACITY);

	// link value written by the sweep at slot i
	assign sweep_link = (32'(sweep_i_q) + 32'd1 < 32'(sweep_n_q)) ?
		LINK_W'(sweep_i_q) + LINK_W'(1) : fspa_pkg::NULL_LINK;

	assign diff    = {1'b0, addr_q} - {1'b0, pool_base_q};
	assign div_sub = REM_W'(slot_size_q) << k_q;

	// status to controller
	assign sts.head_null  = (head_q == fspa_pkg::NULL_LINK);
	assign sts.sweep_last = (32'(sweep_i_q) == 32'(fspa_pkg::CAPACITY - 1));
	assign sts.free_bad   = bad_q;
	assign sts.div_last   = (k_q == '0);
	assign sts.rem_nz     = (rem_q != '0);
	assign sts.out_busy   = out_valid_q & ~out_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q  <= fspa_pkg::BASE_RST;
			slot_size_q  <= fspa_pkg::SIZE_RST;
			slot_count_q <= fspa_pkg::COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fspa_pkg::REG_POOL_BASE:  pool_base_q  <= cfg_data;
				fspa_pkg::REG_SLOT_SIZE:  slot_size_q  <= cfg_data[SIZE_W-1:0];
				fspa_pkg::REG_SLOT_COUNT: slot_count_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// head and sweep control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			sweep_i_q <= '0;
			sweep_n_q <= fspa_pkg::N_RST;
		end else begin
			if (cmd.sweep_start) begin
				sweep_i_q <= '0;
				sweep_n_q <= active_n;
				head_q    <= (active_n != '0) ? '0 : fspa_pkg::NULL_LINK;
			end else if (cmd.sweep_step) begin
				sweep_i_q <= sweep_i_q + SLOT_W'(1);
			end
			if (cmd.alloc_wb) head_q <= rd_q;
			if (cmd.link_null) head_q <= LINK_W'(quo_q);
		end
	end

	// link memory write port select
	always_comb begin
		mem_we = 1'b0;
		mem_wa = sweep_i_q;
		mem_wd = sweep_link;
		if (cmd.sweep_step) begin
			mem_we = 1'b1;
		end else if (cmd.link_null) begin
			mem_we = 1'b1;
			mem_wa = quo_q;
			mem_wd = fspa_pkg::NULL_LINK;
		end else if (cmd.free_w1) begin
			mem_we = 1'b1;
			mem_wa = quo_q;
			mem_wd = rd_q;
		end else if (cmd.free_w2) begin
			mem_we = 1'b1;
			mem_wa = head_q[SLOT_W-1:0];
			mem_wd = LINK_W'(quo_q);
		end
	end

	assign mem_re = cmd.alloc_rd | cmd.free_rd;

	// link memory, registered read of the head entry
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (mem_re) rd_q <= mem[head_q[SLOT_W-1:0]];
	end

	// arithmetic work registers
	always_ff @(posedge clk) begin
		if (cmd.capture) addr_q <= object_address;
		if (cmd.alloc_rd) prod_q <= PROD_W'(head_q[SLOT_W-1:0]) * PROD_W'(slot_size_q);
		if (cmd.free_prep) begin
			off_q   <= diff[ADDR_W-1:0];
			under_q <= diff[ADDR_W];
			lim_q   <= LIM_W'(active_n) * LIM_W'(slot_size_q);
		end
		if (cmd.free_init) begin
			bad_q <= under_q | (off_q >= ADDR_W'(lim_q));
			rem_q <= off_q[REM_W-1:0];
			quo_q <= '0;
			k_q   <= K_W'(SLOT_W - 1);
		end
		// restoring division, one quotient bit a cycle
		if (cmd.div_step) begin
			if (rem_q >= div_sub) begin
				rem_q       <= rem_q - div_sub;
				quo_q[k_q]  <= 1'b1;
			end
			if (k_q != '0) k_q <= k_q - K_W'(1);
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.res_set) begin
			res_addr_q   <= '0;
			res_status_q <= cmd.res_status;
			res_last_q   <= 1'b0;
		end else if (cmd.alloc_wb) begin
			res_addr_q   <= pool_base_q + ADDR_W'(prod_q);
			res_status_q <= fspa_pkg::ST_OK;
			res_last_q   <= (rd_q == fspa_pkg::NULL_LINK);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_addr_q   <= res_addr_q;
			out_status_q <= res_status_q;
			out_last_q   <= res_last_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign alloc_address = out_addr_q;
	assign status        = out_status_q;
	assign last_taken    = out_last_q;

endmodule

// ----- sv/fixed_slot_pool_allocator.sv -----
// ----------------------------------------------------------------------------
// fixed_slot_pool_allocator: free-list allocator for a pool of equal slots
// Allocates and frees fixed-size slots through a singly linked free list
// held in an on-chip link memory; one result word per input word.
// ----------------------------------------------------------------------------
// After reset the block sweeps the link memory to chain all slots, with
// s_axis_tready low; configuration writes are taken throughout. An allocate
// reads the head from the link memory together with the slot address
// multiply, then adds the pool base; a free does the subtract and bound
// check, then a restoring divider that makes one of the ten slot-index
// bits per cycle, then up to two link writes; a rebuild sweeps the whole
// link memory. One word is worked at a time; the next word is accepted
// once the previous result has been loaded into the output register.
module fixed_slot_pool_allocator (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [fspa_pkg::IDX_W-1:0]      cfg_index,
	input  logic [fspa_pkg::ADDR_W-1:0]     cfg_data,
	// input stream
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [fspa_pkg::ADDR_W-1:0]     s_axis_tdata,   // [47:0] object_address
	input  logic [fspa_pkg::OP_W-1:0]       s_axis_tuser,   // [1:0] opcode
	// output stream
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [fspa_pkg::ADDR_W-1:0]     m_axis_tdata,   // [47:0] alloc_address
	output logic [fspa_pkg::STAT_W:0]       m_axis_tuser    // [1:0] status, [2] last_taken
);

	fspa_pkg::cmd_t                 cmd;
	fspa_pkg::sts_t                 sts;
	logic [fspa_pkg::STAT_W-1:0]    res_status;
	logic                           res_last;

	// registers are always writable
	assign cfg_ready = 1'b1;

	fspa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.opcode   (s_axis_tuser),
		.sts      (sts),
		.cmd      (cmd)
	);

	fspa_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.object_address (s_axis_tdata),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.alloc_address  (m_axis_tdata),
		.status         (res_status),
		.last_taken     (res_last)
	);

	assign m_axis_tuser = {res_last, res_status};

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the fixed-slot pool allocator
// Drives allocate, free, rebuild and no-op words with random gaps and
// random output stalls, predicts every result from a private copy of the
// free list and registers, and compares each result word field by field.
// ----------------------------------------------------------------------------
module tb;
	import fspa_pkg::*;

	// opcode 3 has no name in the package; the block treats it as a no-op
	localparam logic [OP_W-1:0] OP_NOP = 2'd3;

	// idle time before a register write: covers a rebuild sweep or the reset sweep
	localparam int SETTLE_CYCLES = 1100;
	localparam int DRAIN_CYCLES  = 50;
	localparam int LIMIT_CYCLES  = 4_000_000;
	localparam int RAND_PHASES   = 8;
	localparam int PHASE_WORDS   = 70;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [STAT_W-1:0] status;
		logic              last;
	} pool_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [IDX_W-1:0]    cfg_index = '0;
	logic [ADDR_W-1:0]   cfg_data = '0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [ADDR_W-1:0]   s_axis_tdata = '0;     // [47:0] object_address
	logic [OP_W-1:0]     s_axis_tuser = '0;     // [1:0] opcode
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [ADDR_W-1:0]   m_axis_tdata;          // [47:0] alloc_address
	logic [STAT_W:0]     m_axis_tuser;          // [1:0] status, [2] last_taken

	// predicted pool state and registers
	logic [LINK_W-1:0]   link_mem [CAPACITY];
	logic [LINK_W-1:0]   head_slot;
	logic [ADDR_W-1:0]   cfg_base;
	logic [SIZE_W-1:0]   cfg_size;
	logic [COUNT_W-1:0]  cfg_count;

	pool_result_t        pending_results [$];
	logic [ADDR_W-1:0]   taken_addrs [$];
	int                  mismatches = 0;
	bit                  no_idle = 1'b0;
	int                  stall_left = 0;

	fixed_slot_pool_allocator u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------
	function automatic int live_slots();
		return (int'(cfg_count) < CAPACITY) ? int'(cfg_count) : CAPACITY;
	endfunction

	function automatic void chain_slots();
		int n;
		int i;
		n = live_slots();
		for (i = 0; i < CAPACITY; i++)
			link_mem[i] = (i + 1 < n) ? LINK_W'(i + 1) : NULL_LINK;
		head_slot = (n > 0) ? LINK_W'(0) : NULL_LINK;
	endfunction

	function automatic pool_result_t predict_pool_op(logic [OP_W-1:0] op,
			logic [ADDR_W-1:0] addr);
		pool_result_t r;
		logic [63:0] off;
		logic [63:0] idx;
		logic [LINK_W-1:0] h;
		logic [LINK_W-1:0] s;
		r = '0;
		case (op)
			OP_ALLOC: begin
				if (head_slot >= NULL_LINK) begin
					r.status = ST_EMPTY;
				end else begin
					h = head_slot;
					r.addr = ADDR_W'(64'(cfg_base) + 64'(h) * 64'(cfg_size));
					head_slot = link_mem[h];
					r.last = (head_slot >= NULL_LINK);
				end
			end
			OP_FREE: begin
				if (addr < cfg_base || cfg_size == '0) begin
					r.status = ST_BAD;
				end else begin
					off = 64'(addr - cfg_base);
					idx = off / 64'(cfg_size);
					if (off % 64'(cfg_size) != 0 || idx >= 64'(live_slots())) begin
						r.status = ST_BAD;
					end else begin
						s = LINK_W'(idx);
						if (head_slot >= NULL_LINK) begin
							link_mem[s] = NULL_LINK;
							head_slot = s;
						end else begin
							link_mem[s] = link_mem[head_slot];
							link_mem[head_slot] = s;
						end
					end
				end
			end
			OP_REBUILD: chain_slots();
			default: ;
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------
	// helpers
	// ------------------------------------------------------------------
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [ADDR_W-1:0] rand_addr();
		return ADDR_W'({$urandom(), $urandom()});
	endfunction

	// send one word and record its predicted result
	task automatic send_word(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr);
		int gap;
		pool_result_t r;
		gap = no_idle ? 0 : gap_len();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= addr;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		r = predict_pool_op(op, addr);
		pending_results.push_back(r);
		if (op == OP_ALLOC && r.status == ST_OK)
			taken_addrs.push_back(r.addr);
		else if (op == OP_REBUILD)
			taken_addrs.delete();
	endtask

	// stop sending, wait for every result, then let the block settle
	task automatic wait_results(int settle);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_POOL_BASE:  cfg_base  = data;
			REG_SLOT_SIZE:  cfg_size  = data[SIZE_W-1:0];
			REG_SLOT_COUNT: cfg_count = data[COUNT_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_pool(logic [ADDR_W-1:0] base, logic [SIZE_W-1:0] size,
			logic [COUNT_W-1:0] count);
		wait_results(SETTLE_CYCLES);
		write_reg(REG_POOL_BASE, base);
		write_reg(REG_SLOT_SIZE, ADDR_W'(size));
		write_reg(REG_SLOT_COUNT, ADDR_W'(count));
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	// reset registers: base 0, 64-byte slots, full pool
	task automatic test_default_pool();
		send_word(OP_ALLOC, '0);
		send_word(OP_ALLOC, '1);
		send_word(OP_FREE, '0);
		send_word(OP_FREE, ADDR_W'(65));                 // off a slot boundary
		send_word(OP_FREE, ADDR_W'(CAPACITY * 64));      // one past the pool
		send_word(OP_FREE, 48'hFFFF_FFFF_FFC0);          // aligned, far outside
		send_word(OP_NOP, '1);
		send_word(OP_FREE, ADDR_W'(2 * 64));             // free the head slot itself
		send_word(OP_ALLOC, '0);
		send_word(OP_ALLOC, '0);
		send_word(OP_REBUILD, '0);
	endtask

	// top base with widest slots, empty pool, zero slot size
	task automatic test_config_extremes();
		set_pool('1, '1, COUNT_W'(2));
		send_word(OP_REBUILD, '0);
		send_word(OP_ALLOC, '0);
		send_word(OP_ALLOC, '0);                         // address wraps, last slot
		send_word(OP_ALLOC, '0);                         // pool empty
		send_word(OP_FREE, '0);                          // below base
		send_word(OP_FREE, '1);                          // into an empty list
		send_word(OP_FREE, '1);                          // double free of the head
		send_word(OP_ALLOC, '0);
		send_word(OP_ALLOC, '0);

		set_pool('0, '0, '0);
		send_word(OP_REBUILD, '1);
		send_word(OP_ALLOC, '0);
		send_word(OP_FREE, '0);

		wait_results(SETTLE_CYCLES);
		write_reg(REG_SLOT_COUNT, ADDR_W'(2047));
		send_word(OP_REBUILD, '0);
		send_word(OP_ALLOC, '0);
		send_word(OP_FREE, '0);                          // zero slot size
	endtask

	// random configurations, mostly well-formed alloc/free traffic
	task automatic test_random_traffic();
		int p;
		int w;
		int k;
		int j;
		int n;
		logic [ADDR_W-1:0] base;
		logic [SIZE_W-1:0] size;
		logic [COUNT_W-1:0] count;
		logic [ADDR_W-1:0] addr;
		for (p = 0; p < RAND_PHASES; p++) begin
			case ($urandom_range(0, 2))
				0: base = '0;
				1: base = rand_addr();
				default: base = '1 - ADDR_W'($urandom_range(0, 4000));
			endcase
			k = $urandom_range(0, 9);
			if (k < 6)
				size = SIZE_W'($urandom_range(1, 16));
			else if (k < 8)
				size = SIZE_W'(1 << $urandom_range(0, 15));
			else
				size = SIZE_W'($urandom_range(1, 65535));
			k = $urandom_range(0, 9);
			if (k < 7)
				count = COUNT_W'($urandom_range(1, 24));
			else if (k < 9)
				count = COUNT_W'($urandom_range(1, CAPACITY));
			else
				count = COUNT_W'(CAPACITY);
			set_pool(base, size, count);
			no_idle = (p == 2);
			// most phases start from a fresh chain; some keep the old one
			if ($urandom_range(0, 3) != 0)
				send_word(OP_REBUILD, rand_addr());
			for (w = 0; w < PHASE_WORDS; w++) begin
				k = $urandom_range(0, 99);
				if (k < 47) begin
					send_word(OP_ALLOC, rand_addr());
				end else if (k < 92) begin
					n = live_slots();
					k = $urandom_range(0, 99);
					if (k < 45 && taken_addrs.size() != 0) begin
						j = $urandom_range(0, taken_addrs.size() - 1);
						addr = taken_addrs[j];
						taken_addrs.delete(j);
					end else if (k < 65) begin
						addr = cfg_base + ADDR_W'($urandom_range(0, n + 1)) * cfg_size;
					end else if (k < 75) begin
						if (cfg_size > 1)
							addr = cfg_base + ADDR_W'($urandom_range(0, n)) * cfg_size
								+ ADDR_W'($urandom_range(1, cfg_size - 1));
						else
							addr = cfg_base - 1;
					end else if (k < 85) begin
						addr = cfg_base - ADDR_W'($urandom_range(1, 1000));
					end else begin
						addr = rand_addr();
					end
					send_word(OP_FREE, addr);
				end else if (k < 96) begin
					send_word(OP_REBUILD, rand_addr());
				end else begin
					send_word(OP_NOP, rand_addr());
				end
			end
		end
		no_idle = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// output side: random stalls, one phase without any
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (no_idle) begin
			m_axis_tready <= 1'b1;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			m_axis_tready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				stall_left <= gap_len();
		end
	end

	// result checker
	always @(posedge clk) begin : check_results
		pool_result_t got;
		pool_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.addr   = m_axis_tdata;
			got.status = m_axis_tuser[STAT_W-1:0];
			got.last   = m_axis_tuser[STAT_W];
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: addr %h status %0d last %0b",
						got.addr, got.status, got.last);
			end else begin
				want = pending_results.pop_front();
				if (got.addr !== want.addr || got.status !== want.status
						|| got.last !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected addr %h status %0d last %0b, got addr %h status %0d last %0b",
							want.addr, want.status, want.last,
							got.addr, got.status, got.last);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		cfg_base  = BASE_RST;
		cfg_size  = SIZE_RST;
		cfg_count = COUNT_RST;
		chain_slots();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_pool();
		test_config_extremes();
		test_random_traffic();
		wait_results(DRAIN_CYCLES);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("[fixed_slot_pool_allocator] OK");
		else
			$display("[fixed_slot_pool_allocator] ERROR");
		$finish;
	end

	// watchdog
	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("[fixed_slot_pool_allocator] ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/fspa_pkg.sv
sv/fspa_ctrl.sv
sv/fspa_dp.sv
sv/fixed_slot_pool_allocator.sv
tb/tb.sv
